[sv/adaptive_rms_peak_detector_unit_defines.svh]
// ----------------------------------------------------------------------------
// adaptive_rms_peak_detector_unit_defines: assertion macros
// Shared concurrent assertion shorthands for the RMS peak detector.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_RMS_PEAK_DETECTOR_UNIT_DEFINES_SVH
`define ADAPTIVE_RMS_PEAK_DETECTOR_UNIT_DEFINES_SVH

// expression holds at every clock edge out of reset
`define ARPD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ARPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ARPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/arpd_pkg.sv]
// ----------------------------------------------------------------------------
// arpd_pkg: shared types and constants
// Payload structs, unit handshake structs and fixed-point constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpd_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 16;   // |sample| fits 16 bits unsigned (max 32768)
   localparam int SQ_W      = 2 * MAG_W;
   localparam int LEVEL_W   = 16;
   localparam int TIME_W    = 32;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int MEAN_W    = 33;   // 4 * mean square <= 2^32
   localparam int RAD_W     = 34;   // even radicand width for the root unit

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ADAPT_RATE   = 2'd0,
      CSR_PEAK_THR     = 2'd1,
      CSR_MIN_INTERVAL = 2'd2
   } csr_idx_type;

   localparam logic [CSR_W-1:0]   RATE_RST    = 16'd655;
   localparam logic [CSR_W-1:0]   THR_RST     = 16'd19661;
   localparam logic [CSR_W-1:0]   INTV_RST    = 16'd500;
   localparam logic [LEVEL_W-1:0] FLOOR_RST   = 16'd1311;
   localparam logic [LEVEL_W-1:0] FLOOR_MIN   = 16'd328;
   localparam logic [LEVEL_W-1:0] FLOOR_MAX   = 16'd19661;
   localparam logic [LEVEL_W-1:0] DEN_MIN     = 16'd3277;
   localparam logic [LEVEL_W-1:0] SIX_TENTHS  = 16'd39322;
   localparam logic [LEVEL_W-1:0] LEVEL_SAT   = 16'hFFFF;
   localparam logic [9:0]         SUP_KEEP    = 10'd999;
   localparam logic [9:0]         SUP_ROUND   = 10'd500;
   localparam logic [9:0]         SUP_DIV     = 10'd1000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       chunk_end;
      logic [TIME_W-1:0]          now_ms;
      logic                       suppress;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] rms_level;
      logic [LEVEL_W-1:0] strength;
      logic               peak;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic clear;
   } acc_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [LEVEL_W-1:0] clamp_floor(input logic [31:0] f);
      logic [LEVEL_W-1:0] r;
      if (f < 32'(FLOOR_MIN)) begin
         r = FLOOR_MIN;
      end else if (f > 32'(FLOOR_MAX)) begin
         r = FLOOR_MAX;
      end else begin
         r = f[LEVEL_W-1:0];
      end
      return r;
   endfunction

endpackage

[sv/arpd_sqacc.sv]
// ----------------------------------------------------------------------------
// arpd_sqacc: bit-serial square accumulator
// Squares a sample magnitude by shift-and-add, one multiplier bit per cycle,
// into the chunk sum; also holds the chunk sample count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpd_sqacc
   import arpd_pkg::*;
#(
   parameter int CHUNK_LEN = 256,
   localparam int SUM_W  = 31 + $clog2(CHUNK_LEN),
   localparam int CNT_W  = $clog2(CHUNK_LEN + 1),
   localparam int STEP_W = $clog2(MAG_W + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  acc_ctl_type       ctl,
   input  logic [MAG_W-1:0]  mag,
   output unit_stat_type     stat,
   output logic              full,
   output logic [SUM_W-1:0]  sum,
   output logic [CNT_W-1:0]  count
);

   logic [SQ_W-1:0]   mcand_ff,  mcand_in;
   logic [MAG_W-1:0]  mplier_ff, mplier_in;
   logic [STEP_W-1:0] step_ff,   step_in;
   logic [SUM_W-1:0]  sum_ff,    sum_in;
   logic [CNT_W-1:0]  cnt_ff,    cnt_in;
   logic              busy_ff,   busy_in;
   logic              done_ff,   done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      step_in   = step_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            sum_in = sum_ff + SUM_W'(mcand_ff);
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         step_in   = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         mcand_in  = SQ_W'(mag);
         mplier_in = mag;
         step_in   = STEP_W'(MAG_W);
         busy_in   = 1'b1;
         cnt_in    = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      step_ff   <= step_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign full      = (cnt_ff == CNT_W'(CHUNK_LEN));
   assign sum       = sum_ff;
   assign count     = cnt_ff;

endmodule

[sv/arpd_div.sv]
// ----------------------------------------------------------------------------
// arpd_div: serial restoring divider
// One quotient bit per cycle, MSB first; quotient holds until next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpd_div
   import arpd_pkg::*;
#(
   parameter int DVD_W = 41,
   parameter int DSR_W = 16,
   localparam int STEP_W = $clog2(DVD_W + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output unit_stat_type    stat,
   output logic [DVD_W-1:0] quotient
);

   logic [DVD_W-1:0]  quo_ff,  quo_in;
   logic [DSR_W-1:0]  rem_ff,  rem_in;
   logic [DSR_W-1:0]  dsr_ff,  dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DSR_W:0]    trial;
   logic [DSR_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rem_in  = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

[sv/arpd_isqrt.sv]
// ----------------------------------------------------------------------------
// arpd_isqrt: serial integer square root
// Digit-by-digit, two radicand bits and one root bit per cycle (floor root).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpd_isqrt
   import arpd_pkg::*;
#(
   parameter int RAD_W = 34,
   localparam int ROOT_W = RAD_W / 2,
   localparam int REM_W  = ROOT_W + 2,
   localparam int STEP_W = $clog2(ROOT_W + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output unit_stat_type     stat,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff,  rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   // remainder stays below 2*root + 1, so its top two bits are free here
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rad_in  = rad_ff << 2;
         step_in = step_ff - 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         step_in = STEP_W'(ROOT_W);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

[sv/adaptive_rms_peak_detector_unit.sv]
// ----------------------------------------------------------------------------
// adaptive_rms_peak_detector_unit: chunk RMS level and sound peak detector
// Ordinary sample: the next request is taken once the serial squarer is done.
// Chunk end: the response follows up to two passes of the shared one-bit-per-cycle
//   divider and the 17-step root; DVD_W = 33 + clog2(CHUNK_LEN).
// One request in flight; a finished response waits in its register while input is taken.
// Sync reset: registers to defaults, floor 1311, sum, count and last peak time zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adaptive_rms_peak_detector_unit_defines.svh"

module adaptive_rms_peak_detector_unit
   import arpd_pkg::*;
#(
   parameter int CHUNK_LEN = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   // register write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // sum of squares: 2^30 per sample times CHUNK_LEN samples
   localparam int SUM_W  = 31 + $clog2(CHUNK_LEN);
   localparam int CNT_W  = $clog2(CHUNK_LEN + 1);
   // divider dividend is 4*sum, which also covers the 32-bit strength dividend
   localparam int DVD_W  = SUM_W + 2;
   localparam int DSR_W  = LEVEL_W;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SUPP_W = 26;          // floor * 999 < 2^25
   localparam int PROD_W = 34;          // signed 17 x 17 product
   localparam int ADP_W  = PROD_W + 1;
   localparam int ROUND_HALF = 32768;

   // Sequencer. A sample goes through the serial squarer; a chunk end then
   // walks mean -> root -> [floor update] -> [strength -> peak] -> response.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,        // squarer running
      ST_MEAN_GO,   // start 4*sum / count, clear accumulator
      ST_MEAN,
      ST_ROOT_GO,
      ST_ROOT,
      ST_BRANCH,    // zero level / suppressed / normal
      ST_SUP_MUL,   // floor * 999
      ST_SUP_GO,    // start (floor*999 + rms + 500) / 1000
      ST_SUP_DIV,
      ST_ADP_MUL,   // (rms - floor) * rate
      ST_ADP_ADD,   // floor<<16 + product + half, take the upper part
      ST_STR_GO,    // start (rms - floor)<<16 / den, or strength 0
      ST_STR_DIV,
      ST_PEAK,      // threshold and interval check
      ST_OUT        // load response register
   } state_type;

   state_type                  state_ff,  state_in;
   logic [CSR_W-1:0]           rate_ff,   rate_in;
   logic [CSR_W-1:0]           thr_ff,    thr_in;
   logic [CSR_W-1:0]           intv_ff,   intv_in;
   logic [LEVEL_W-1:0]         floor_ff,  floor_in;
   logic [TIME_W-1:0]          last_ff,   last_in;
   logic [TIME_W-1:0]          now_ff,    now_in;
   logic                       sup_ff,    sup_in;
   logic                       end_ff,    end_in;
   logic [LEVEL_W-1:0]         rms_ff,    rms_in;
   logic [LEVEL_W-1:0]         str_ff,    str_in;
   logic                       peak_ff,   peak_in;
   logic signed [PROD_W-1:0]   prod_ff,   prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff,  rsp_data_in;

   // unit hookup
   acc_ctl_type                acc_ctl;
   unit_stat_type              acc_stat;
   logic                       acc_full;
   logic [SUM_W-1:0]           acc_sum;
   logic [CNT_W-1:0]           acc_count;
   logic                       div_start;
   logic [DVD_W-1:0]           div_dividend;
   logic [DSR_W-1:0]           div_divisor;
   unit_stat_type              div_stat;
   logic [DVD_W-1:0]           div_quo;
   logic                       sqrt_start;
   unit_stat_type              sqrt_stat;
   logic [ROOT_W-1:0]          sqrt_root;

   // datapath helpers
   logic                       accept;
   logic [MAG_W-1:0]           mag;
   logic [LEVEL_W-1:0]         rms_sat;
   logic [LEVEL_W-1:0]         str_sat;
   logic                       rms_above;
   logic                       adapt_ok;
   logic [LEVEL_W-1:0]         den_raw;
   logic [LEVEL_W-1:0]         den;
   logic [SUPP_W-1:0]          sup_prod;
   logic signed [LEVEL_W:0]    diff_s;
   logic signed [LEVEL_W:0]    rate_s;
   logic signed [PROD_W-1:0]   adp_prod;
   logic signed [ADP_W-1:0]    adp_sum;
   logic [TIME_W-1:0]          elapsed;

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   arpd_sqacc #(
      .CHUNK_LEN (CHUNK_LEN)
   ) u_sqacc (
      .clock (clock),
      .reset (reset),
      .ctl   (acc_ctl),
      .mag   (mag),
      .stat  (acc_stat),
      .full  (acc_full),
      .sum   (acc_sum),
      .count (acc_count)
   );

   arpd_div #(
      .DVD_W (DVD_W),
      .DSR_W (DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   arpd_isqrt #(
      .RAD_W (RAD_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (RAD_W'(div_quo[MEAN_W-1:0])),
      .stat     (sqrt_stat),
      .root     (sqrt_root)
   );

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // |sample|; -32768 gives 0x8000, still in range as unsigned
   assign mag = req_data.sample[SAMPLE_W-1] ? MAG_W'(~req_data.sample + 1'b1)
                                            : MAG_W'(req_data.sample);

   // Samples past CHUNK_LEN are dropped, but their chunk_end still counts.
   assign acc_ctl.start = accept && !acc_full;
   assign acc_ctl.clear = (state_ff == ST_MEAN_GO);

   // root of 4*mean reaches 65536 only for full-scale negative samples
   assign rms_sat = sqrt_root[ROOT_W-1] ? LEVEL_SAT : sqrt_root[LEVEL_W-1:0];
   assign str_sat = (div_quo[DVD_W-1:LEVEL_W] != '0) ? LEVEL_SAT : div_quo[LEVEL_W-1:0];

   assign rms_above = (rms_ff > floor_ff);
   // adapt only while 2*rms < 3*floor
   assign adapt_ok  = ((18'(rms_ff) << 1) < (18'(floor_ff) + (18'(floor_ff) << 1)));

   // normalizer max(0.05, 0.6 - floor)
   assign den_raw = (floor_ff < SIX_TENTHS) ? (SIX_TENTHS - floor_ff) : '0;
   assign den     = (den_raw < DEN_MIN) ? DEN_MIN : den_raw;

   assign sup_prod = SUPP_W'(floor_ff) * SUPP_W'(SUP_KEEP);

   // floor*(1-w) + rms*w == floor + (rms-floor)*w, one signed multiply
   assign diff_s   = $signed({1'b0, rms_ff}) - $signed({1'b0, floor_ff});
   assign rate_s   = $signed({1'b0, rate_ff});
   assign adp_prod = PROD_W'(diff_s) * PROD_W'(rate_s);
   assign adp_sum  = ADP_W'($signed({1'b0, floor_ff, 16'h0000})) + ADP_W'(prod_ff)
                   + ADP_W'(ROUND_HALF);

   assign elapsed = now_ff - last_ff;

   assign sqrt_start = (state_ff == ST_ROOT_GO);
   assign div_start  = (state_ff == ST_MEAN_GO) || (state_ff == ST_SUP_GO)
                    || ((state_ff == ST_STR_GO) && rms_above);

   always_comb begin
      unique case (state_ff)
         ST_MEAN_GO: begin
            div_dividend = {acc_sum, 2'b00};
            div_divisor  = DSR_W'(acc_count);
         end
         ST_SUP_GO: begin
            div_dividend = DVD_W'(prod_ff[SUPP_W-1:0]) + DVD_W'(rms_ff) + DVD_W'(SUP_ROUND);
            div_divisor  = DSR_W'(SUP_DIV);
         end
         default: begin
            div_dividend = DVD_W'({rms_ff - floor_ff, 16'h0000});
            div_divisor  = den;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer and registers
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      thr_in       = thr_ff;
      intv_in      = intv_ff;
      floor_in     = floor_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      sup_in       = sup_ff;
      end_in       = end_ff;
      rms_in       = rms_ff;
      str_in       = str_ff;
      peak_in      = peak_ff;
      prod_in      = prod_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // register writes; unknown index is dropped
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ADAPT_RATE:   rate_in = csr_wdata;
            CSR_PEAK_THR:     thr_in  = csr_wdata;
            CSR_MIN_INTERVAL: intv_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               now_in = req_data.now_ms;
               sup_in = req_data.suppress;
               end_in = req_data.chunk_end;
               if (!acc_full) begin
                  state_in = ST_SQ;
               end else if (req_data.chunk_end) begin
                  state_in = ST_MEAN_GO;
               end
            end
         end
         ST_SQ: begin
            if (acc_stat.done) begin
               state_in = end_ff ? ST_MEAN_GO : ST_IDLE;
            end
         end
         ST_MEAN_GO: state_in = ST_MEAN;
         ST_MEAN: begin
            if (div_stat.done) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sqrt_stat.done) begin
               rms_in   = rms_sat;
               str_in   = '0;
               peak_in  = 1'b0;
               state_in = ST_BRANCH;
            end
         end
         ST_BRANCH: begin
            // zero level: report zeros, floor and peak time untouched
            priority if (rms_ff == '0) begin
               state_in = ST_OUT;
            end else if (sup_ff) begin
               state_in = ST_SUP_MUL;
            end else if (adapt_ok) begin
               state_in = ST_ADP_MUL;
            end else begin
               state_in = ST_STR_GO;
            end
         end
         ST_SUP_MUL: begin
            prod_in  = PROD_W'(sup_prod);
            state_in = ST_SUP_GO;
         end
         ST_SUP_GO: state_in = ST_SUP_DIV;
         ST_SUP_DIV: begin
            if (div_stat.done) begin
               floor_in = clamp_floor(div_quo[31:0]);
               state_in = ST_OUT;
            end
         end
         ST_ADP_MUL: begin
            prod_in  = adp_prod;
            state_in = ST_ADP_ADD;
         end
         ST_ADP_ADD: begin
            // sum is never negative: a weighted mean of floor and rms
            floor_in = clamp_floor(32'(adp_sum[ADP_W-2:16]));
            state_in = ST_STR_GO;
         end
         ST_STR_GO: begin
            state_in = rms_above ? ST_STR_DIV : ST_PEAK;
         end
         ST_STR_DIV: begin
            if (div_stat.done) begin
               str_in   = str_sat;
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            // wrapping time difference against the minimum spacing
            if ((str_ff >= thr_ff) && (elapsed >= TIME_W'(intv_ff))) begin
               peak_in = 1'b1;
               last_in = now_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.rms_level = rms_ff;
               rsp_data_in.strength  = str_ff;
               rsp_data_in.peak      = peak_ff;
               state_in              = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_RST;
         thr_ff       <= THR_RST;
         intv_ff      <= INTV_RST;
         floor_ff     <= FLOOR_RST;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         thr_ff       <= thr_in;
         intv_ff      <= intv_in;
         floor_ff     <= floor_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      sup_ff      <= sup_in;
      end_ff      <= end_in;
      rms_ff      <= rms_in;
      str_ff      <= str_in;
      peak_ff     <= peak_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ARPD_ASSERT_IMPLIES(a_div_start_idle, clock, reset, div_start, !div_stat.busy, "divider restarted while busy")
   `ARPD_ASSERT_IMPLIES(a_sqrt_start_idle, clock, reset, sqrt_start, !sqrt_stat.busy, "root restarted while busy")
   `ARPD_ASSERT_IMPLIES(a_acc_start_idle, clock, reset, acc_ctl.start, !acc_stat.busy && !acc_full, "squarer started while busy or full")
   `ARPD_ASSERT_ALWAYS(a_floor_range, clock, reset, (floor_ff >= FLOOR_MIN) && (floor_ff <= FLOOR_MAX), "noise floor out of clamp range")
   `ARPD_ASSERT_ALWAYS(a_count_bound, clock, reset, acc_count <= CNT_W'(CHUNK_LEN), "chunk count past chunk length")
   `ARPD_ASSERT_NEXT(a_out_loads, clock, reset, (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE), "response not loaded")

endmodule
